@@ src/spm_pkg.sv @@
package spm_pkg;

  typedef enum logic [1:0] {
    ACT_STAY    = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_LEFT    = 2'd2,
    ACT_RIGHT   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_RELAY = 2'd0,
    MODE_P     = 2'd1,
    MODE_PD    = 2'd2,
    MODE_PID   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_GAIN_P      = 3'd1,
    REG_GAIN_D      = 3'd2,
    REG_GAIN_I      = 3'd3,
    REG_STOP_WIDTH  = 3'd4,
    REG_MOVE_WIDTH  = 3'd5,
    REG_LEFT_WIDTH  = 3'd6,
    REG_RIGHT_WIDTH = 3'd7
  } reg_index_t;

  localparam int ERR_W     = 15;
  localparam int ROOT_W    = 14;
  localparam int RAD_W     = 27;                  // err << 12
  localparam int FRAC_BITS = 20;

  localparam logic [10:0] WIDTH_MIN = 11'd1000;
  localparam logic [10:0] WIDTH_MAX = 11'd2000;
  localparam logic [26:0] U_OFFSET  = 27'(100 << FRAC_BITS);

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] heading_error;
    logic               obstacle_near;
  } in_item_t;

  typedef struct packed {
    logic [10:0]        steering_width;
    logic [10:0]        throttle_width;
    logic signed [15:0] drive_value;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    action_t          action;
    logic [ERR_W-1:0] err;
    logic             obstacle;
    logic             turning;
  } cmd_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] gain_p;
    logic [15:0] gain_d;
    logic [15:0] gain_i;
    logic [10:0] stop_width;
    logic [10:0] move_width;
    logic [10:0] left_width;
    logic [10:0] right_width;
  } cfg_t;

  function automatic logic [10:0] sat_width(input logic signed [17:0] w);
    logic [10:0] r;
    if (w < $signed({7'b0, WIDTH_MIN})) begin
      r = WIDTH_MIN;
    end else if (w > $signed({7'b0, WIDTH_MAX})) begin
      r = WIDTH_MAX;
    end else begin
      r = w[10:0];
    end
    return r;
  endfunction

endpackage

@@ src/spm_front.sv @@
module spm_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  spm_pkg::in_item_t in_item,
  output logic              push,
  input  logic              full,
  output spm_pkg::cmd_t     cmd
);

  logic               held;
  spm_pkg::cmd_t      cmd_reg;
  spm_pkg::cmd_t      cmd_next;
  logic               take;
  logic signed [16:0] h_ext;
  logic [16:0]        h_mag;

  assign in_stall = held && full;
  assign take     = in_valid && !in_stall;
  assign push     = held;
  assign cmd      = cmd_reg;

  always_comb begin
    h_ext = {in_item.heading_error[15], in_item.heading_error};
    h_mag = in_item.heading_error[15] ? 17'(-h_ext) : 17'(h_ext);
    cmd_next.action   = spm_pkg::action_t'(in_item.action);
    // most negative error saturates to the largest magnitude
    cmd_next.err      = h_mag[16:15] != 2'b00 ? {spm_pkg::ERR_W{1'b1}} : h_mag[14:0];
    cmd_next.obstacle = in_item.obstacle_near;
    cmd_next.turning  = in_item.action == spm_pkg::ACT_LEFT ||
                        in_item.action == spm_pkg::ACT_RIGHT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (take) begin
      held <= 1'b1;
    end else if (held && !full) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_reg <= cmd_next;
    end
  end

endmodule

@@ src/spm_fifo.sv @@
module spm_fifo #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output spm_pkg::cmd_t pop_data,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  spm_pkg::cmd_t    slot [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_en;
  logic             rd_en;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign wr_en    = push && !full;
  assign rd_en    = pop && !empty;
  assign pop_data = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr == LAST ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr == LAST ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> count == CNT_W'($past(count) + 1'b1))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en |=> count == CNT_W'($past(count) - 1'b1))
    else $error("queue count missed a pop");

endmodule

@@ src/spm_back.sv @@
module spm_back (
  input  logic               clk,
  input  logic               rst,
  input  spm_pkg::cfg_t      cfg,
  output logic               pop,
  input  logic               empty,
  input  spm_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_stall,
  output spm_pkg::out_item_t out_item
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_MUL,
    S_ACC,
    S_SUM,
    S_DONE
  } state_t;

  state_t                        state;
  spm_pkg::cmd_t                 cur;
  logic [spm_pkg::RAD_W-1:0]     rad;
  logic [spm_pkg::RAD_W-1:0]     res;
  logic [spm_pkg::RAD_W-1:0]     bitv;
  logic [29:0]                   p_term;
  logic signed [31:0]            d_term;
  logic [30:0]                   i_term;
  logic signed [33:0]            partial;
  logic [31:0]                   ival;
  logic signed [34:0]            u;
  logic [spm_pkg::ERR_W-1:0]     prev_error;
  logic [31:0]                   integral_sum;

  logic                          compute;
  logic                          out_free;
  logic                          use_d;
  logic                          use_i;
  logic [spm_pkg::RAD_W:0]       trial;
  logic                          fits;
  logic [spm_pkg::ROOT_W-1:0]    root;
  logic signed [16:0]            d_diff;
  logic signed [33:0]            d_prod;
  logic [32:0]                   isum;
  logic [31:0]                   isat;
  logic [34:0]                   umag;
  logic [14:0]                   mag;
  logic signed [15:0]            drive;
  logic [10:0]                   steer;
  logic [10:0]                   throttle;
  spm_pkg::out_item_t            out_next;

  assign pop      = state == S_IDLE && !empty;
  assign compute  = cmd.turning && cfg.mode != spm_pkg::MODE_RELAY;
  assign out_free = !out_valid || !out_stall;
  assign use_d    = cfg.mode == spm_pkg::MODE_PD || cfg.mode == spm_pkg::MODE_PID;
  assign use_i    = cfg.mode == spm_pkg::MODE_PID;
  assign root     = res[spm_pkg::ROOT_W-1:0];

  // one root bit per cycle
  assign trial = {1'b0, res} + {1'b0, bitv};
  assign fits  = {1'b0, rad} >= trial;

  assign d_diff = $signed({2'b00, cur.err}) - $signed({2'b00, prev_error});
  assign d_prod = $signed({1'b0, cfg.gain_d}) * d_diff;

  assign isum = {1'b0, integral_sum} + {2'b00, i_term};
  assign isat = isum[32] ? '1 : isum[31:0];

  always_comb begin
    umag  = u[34] ? 35'(-u) : 35'(u);
    // |u| stays below 2^33, so the integer part fits without clipping
    mag   = umag[34:spm_pkg::FRAC_BITS];
    drive = cur.action == spm_pkg::ACT_LEFT ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    throttle = spm_pkg::sat_width($signed({7'b0, cfg.stop_width}));
    if (cur.obstacle || cur.action == spm_pkg::ACT_STAY) begin
      steer = spm_pkg::sat_width($signed({7'b0, cfg.stop_width}));
    end else if (cur.action == spm_pkg::ACT_FORWARD) begin
      steer    = spm_pkg::sat_width($signed({7'b0, cfg.stop_width}));
      throttle = spm_pkg::sat_width($signed({7'b0, cfg.move_width}));
    end else if (cfg.mode == spm_pkg::MODE_RELAY) begin
      steer = spm_pkg::sat_width($signed({7'b0, cur.action == spm_pkg::ACT_LEFT ?
                                                  cfg.left_width : cfg.right_width}));
    end else begin
      steer = spm_pkg::sat_width($signed({7'b0, cfg.stop_width}) +
                                 $signed({{2{drive[15]}}, drive}));
    end

    out_next.steering_width = steer;
    out_next.throttle_width = throttle;
    out_next.drive_value    = drive;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      prev_error   <= '0;
      integral_sum <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            state <= compute ? S_ROOT : S_DONE;
          end
        end
        S_ROOT: begin
          if (bitv[0]) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (use_i) begin
            integral_sum <= isat;
          end
          if (use_d) begin
            prev_error <= cur.err;
          end
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_item <= out_next;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (pop) begin
          cur  <= cmd;
          rad  <= {cmd.err, 12'b0};
          res  <= '0;
          bitv <= spm_pkg::RAD_W'(1) << (spm_pkg::RAD_W - 1);
          u    <= '0;
        end
      end
      S_ROOT: begin
        if (fits) begin
          rad <= spm_pkg::RAD_W'({1'b0, rad} - trial);
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
      end
      S_MUL: begin
        p_term <= cfg.gain_p * root;
        d_term <= 32'(d_prod);
        i_term <= cfg.gain_i * cur.err;
      end
      S_ACC: begin
        partial <= $signed(34'(p_term)) + $signed(34'(spm_pkg::U_OFFSET)) +
                   (use_d ? 34'(d_term) : 34'sd0);
        ival    <= use_i ? isat : '0;
      end
      S_SUM: begin
        u <= $signed({partial[33], partial}) + $signed({3'b000, ival});
      end
      default: begin
      end
    endcase
  end

  a_root_exact: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |->
      (28'(root) * 28'(root)) <= 28'({cur.err, 12'b0}) &&
      ((28'(root) + 28'd1) * (28'(root) + 28'd1)) > 28'({cur.err, 12'b0}))
    else $error("square root not exact");

  a_width_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      out_item.steering_width >= spm_pkg::WIDTH_MIN &&
      out_item.steering_width <= spm_pkg::WIDTH_MAX &&
      out_item.throttle_width >= spm_pkg::WIDTH_MIN &&
      out_item.throttle_width <= spm_pkg::WIDTH_MAX)
    else $error("pulse width out of range");

  a_left_sign: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_free && cur.action == spm_pkg::ACT_LEFT |=>
      out_item.drive_value <= 16'sd0)
    else $error("left turn gave positive drive");

  a_state_update: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (!$stable(prev_error) || !$stable(integral_sum)) |->
      $past(state) == S_ACC)
    else $error("controller state changed outside accumulate step");

endmodule

@@ src/steering_pid_rc_mapper.sv @@
// Stay, forward and relay items pass the front register and the queue, then go from
//   idle straight to the output state; P/PD/PID turn items also pass a 14-step square
//   root, multiply, accumulate and sum before output. The back end takes the next
//   item only after the last is output; the queue holds new items meanwhile.
// Reset (rst, synchronous): config returns to defaults, previous error and
//   integral clear, the queue empties and no result is pending.
module steering_pid_rc_mapper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  spm_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output spm_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  spm_pkg::cfg_t cfg;
  spm_pkg::cmd_t front_cmd;
  spm_pkg::cmd_t queue_cmd;
  logic          push;
  logic          full;
  logic          pop;
  logic          empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode        <= spm_pkg::MODE_PID;
      cfg.gain_p      <= 16'd256;
      cfg.gain_d      <= 16'd0;
      cfg.gain_i      <= 16'd0;
      cfg.stop_width  <= 11'd1500;
      cfg.move_width  <= 11'd1600;
      cfg.left_width  <= 11'd1400;
      cfg.right_width <= 11'd1600;
    end else if (cfg_valid && cfg_ready) begin
      case (spm_pkg::reg_index_t'(cfg_index))
        spm_pkg::REG_MODE:        cfg.mode        <= spm_pkg::mode_t'(cfg_data[1:0]);
        spm_pkg::REG_GAIN_P:      cfg.gain_p      <= cfg_data;
        spm_pkg::REG_GAIN_D:      cfg.gain_d      <= cfg_data;
        spm_pkg::REG_GAIN_I:      cfg.gain_i      <= cfg_data;
        spm_pkg::REG_STOP_WIDTH:  cfg.stop_width  <= cfg_data[10:0];
        spm_pkg::REG_MOVE_WIDTH:  cfg.move_width  <= cfg_data[10:0];
        spm_pkg::REG_LEFT_WIDTH:  cfg.left_width  <= cfg_data[10:0];
        spm_pkg::REG_RIGHT_WIDTH: cfg.right_width <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  spm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .push     (push),
    .full     (full),
    .cmd      (front_cmd)
  );

  spm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (queue_cmd),
    .empty     (empty)
  );

  spm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop       (pop),
    .empty     (empty),
    .cmd       (queue_cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  localparam int     HALF_PERIOD = 6;
  localparam int     CYCLE_LIMIT = 500000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     PHASES      = 10;
  localparam int     PHASE_ITEMS = 125;
  localparam longint INTEG_MAX   = 64'h0000_0000_FFFF_FFFF;

  // Mirrors the block's registers and loop state, queues the expected pulse widths.
  class pulse_checker;
    spm_pkg::mode_t     mode;
    logic [15:0]        gain_p, gain_d, gain_i;
    logic [10:0]        stop_w, move_w, left_w, right_w;
    logic [14:0]        prev_err;
    logic [31:0]        integ;
    spm_pkg::out_item_t pending_pulses[$];
    int                 mismatches;

    function new();
      mode       = spm_pkg::MODE_PID;
      gain_p     = 16'd256;
      gain_d     = 16'd0;
      gain_i     = 16'd0;
      stop_w     = 11'd1500;
      move_w     = 11'd1600;
      left_w     = 11'd1400;
      right_w    = 11'd1600;
      prev_err   = '0;
      integ      = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(spm_pkg::reg_index_t idx, logic [15:0] data);
      case (idx)
        spm_pkg::REG_MODE:        mode    = spm_pkg::mode_t'(data[1:0]);
        spm_pkg::REG_GAIN_P:      gain_p  = data;
        spm_pkg::REG_GAIN_D:      gain_d  = data;
        spm_pkg::REG_GAIN_I:      gain_i  = data;
        spm_pkg::REG_STOP_WIDTH:  stop_w  = data[10:0];
        spm_pkg::REG_MOVE_WIDTH:  move_w  = data[10:0];
        spm_pkg::REG_LEFT_WIDTH:  left_w  = data[10:0];
        spm_pkg::REG_RIGHT_WIDTH: right_w = data[10:0];
        default: ;
      endcase
    endfunction

    // floor(sqrt(v)), v is err in Q.12 so the root comes out in Q.6
    function logic [13:0] q12_root(logic [26:0] v);
      logic [13:0] r;
      logic [13:0] t;
      r = '0;
      for (int b = 13; b >= 0; b--) begin
        t = r | (14'd1 << b);
        if (longint'(t) * longint'(t) <= longint'(v)) r = t;
      end
      return r;
    endfunction

    function logic [10:0] clamp_width(longint w);
      if (w < longint'(spm_pkg::WIDTH_MIN)) return spm_pkg::WIDTH_MIN;
      if (w > longint'(spm_pkg::WIDTH_MAX)) return spm_pkg::WIDTH_MAX;
      return w[10:0];
    endfunction

    function spm_pkg::out_item_t compute_pulse(spm_pkg::in_item_t cmd);
      spm_pkg::out_item_t r;
      int                 mag_h;
      logic [14:0]        err;
      longint             u, mag, drive, acc;
      drive = 0;
      if (cmd.action[1] && mode != spm_pkg::MODE_RELAY) begin
        mag_h = cmd.heading_error;
        if (mag_h < 0) mag_h = -mag_h;
        if (mag_h > 32767) mag_h = 32767;
        err = mag_h[14:0];
        // all terms in Q.20
        u = longint'(gain_p) * longint'(q12_root({err, 12'd0})) +
            longint'(spm_pkg::U_OFFSET);
        if (mode == spm_pkg::MODE_PD || mode == spm_pkg::MODE_PID) begin
          u += longint'(gain_d) * (longint'(err) - longint'(prev_err));
          if (mode == spm_pkg::MODE_PID) begin
            acc = longint'(integ) + longint'(gain_i) * longint'(err);
            if (acc > INTEG_MAX) acc = INTEG_MAX;
            integ = acc[31:0];
            u += longint'(integ);
          end
          prev_err = err;
        end
        // left turns steer negative, right turns positive
        if ((cmd.action == spm_pkg::ACT_LEFT && u > 0) ||
            (cmd.action == spm_pkg::ACT_RIGHT && u < 0)) u = -u;
        mag = (u < 0 ? -u : u) >> spm_pkg::FRAC_BITS;
        if (u < 0) drive = (mag > 32768) ? -32768 : -mag;
        else drive = (mag > 32767) ? 32767 : mag;
      end
      r.steering_width = clamp_width(stop_w);
      r.throttle_width = clamp_width(stop_w);
      if (!cmd.obstacle_near) begin
        if (cmd.action == spm_pkg::ACT_FORWARD) begin
          r.throttle_width = clamp_width(move_w);
        end else if (cmd.action[1]) begin
          if (mode == spm_pkg::MODE_RELAY)
            r.steering_width = clamp_width(cmd.action == spm_pkg::ACT_LEFT ?
                                           left_w : right_w);
          else
            r.steering_width = clamp_width(longint'(stop_w) + drive);
        end
      end
      r.drive_value = drive[15:0];
      return r;
    endfunction

    function void note_command(spm_pkg::in_item_t cmd);
      pending_pulses.push_back(compute_pulse(cmd));
    endfunction

    function void check_pulse(spm_pkg::out_item_t got);
      spm_pkg::out_item_t want;
      if (pending_pulses.size() == 0) begin
        $error("result item with no command pending");
        mismatches++;
        return;
      end
      want = pending_pulses.pop_front();
      if (got.steering_width !== want.steering_width) begin
        $error("steering_width: expected %0d, got %0d", want.steering_width, got.steering_width);
        mismatches++;
      end
      if (got.throttle_width !== want.throttle_width) begin
        $error("throttle_width: expected %0d, got %0d", want.throttle_width, got.throttle_width);
        mismatches++;
      end
      if (got.drive_value !== want.drive_value) begin
        $error("drive_value: expected %0d, got %0d", want.drive_value, got.drive_value);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  spm_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  spm_pkg::out_item_t out_item;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data  = '0;

  pulse_checker sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int last_heading  = 0;
  int cycles        = 0;

  steering_pid_rc_mapper DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // output back-pressure; a requested hold-off is counted down here
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.apply_reg(spm_pkg::reg_index_t'(cfg_index), cfg_data);
      if (in_valid && !in_stall) sb.note_command(in_item);
      if (out_valid && !out_stall) sb.check_pulse(out_item);
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_cmd(spm_pkg::in_item_t cmd);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_fields(spm_pkg::action_t a, int heading, bit obstacle);
    spm_pkg::in_item_t cmd;
    cmd.action        = a;
    cmd.heading_error = heading[15:0];
    cmd.obstacle_near = obstacle;
    send_cmd(cmd);
  endtask

  // drop valid and wait until every expected item has come back
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_pulses.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(spm_pkg::reg_index_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_regs(logic [15:0] m, logic [15:0] kp, logic [15:0] kd,
                              logic [15:0] ki, logic [15:0] sw, logic [15:0] mw,
                              logic [15:0] lw, logic [15:0] rw);
    write_cfg(spm_pkg::REG_MODE, m);
    write_cfg(spm_pkg::REG_GAIN_P, kp);
    write_cfg(spm_pkg::REG_GAIN_D, kd);
    write_cfg(spm_pkg::REG_GAIN_I, ki);
    write_cfg(spm_pkg::REG_STOP_WIDTH, sw);
    write_cfg(spm_pkg::REG_MOVE_WIDTH, mw);
    write_cfg(spm_pkg::REG_LEFT_WIDTH, lw);
    write_cfg(spm_pkg::REG_RIGHT_WIDTH, rw);
  endtask

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1023));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_width();
    case ($urandom_range(7))
      0:       return 16'd1000;
      1:       return 16'd2000;
      2:       return 16'($urandom_range(2047));
      3:       return 16'($urandom);
      default: return 16'($urandom_range(2000, 1000));
    endcase
  endfunction

  // turns dominate; headings often drift slowly so PD/PID state builds up
  function automatic spm_pkg::in_item_t rand_cmd();
    spm_pkg::in_item_t cmd;
    int                sel;
    int                step;
    sel = $urandom_range(9);
    case (sel)
      0:          cmd.action = spm_pkg::ACT_STAY;
      1:          cmd.action = spm_pkg::ACT_FORWARD;
      2, 3, 4, 5: cmd.action = spm_pkg::ACT_LEFT;
      default:    cmd.action = spm_pkg::ACT_RIGHT;
    endcase
    sel = $urandom_range(9);
    if (sel == 0) begin
      case ($urandom_range(4))
        0:       last_heading = -32768;
        1:       last_heading = 32767;
        2:       last_heading = 0;
        3:       last_heading = 1;
        default: last_heading = -1;
      endcase
    end else if (sel <= 4) begin
      step = int'($urandom_range(512)) - 256;
      last_heading = last_heading + step;
      if (last_heading > 32767) last_heading = 32767;
      if (last_heading < -32768) last_heading = -32768;
    end else begin
      last_heading = int'($signed(16'($urandom)));
    end
    cmd.heading_error = last_heading[15:0];
    cmd.obstacle_near = ($urandom_range(9) == 0);
    return cmd;
  endfunction

  initial begin
    sb = new();
    send_idle_pct = 33;
    recv_idle_pct = 55;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: PID, unit proportional gain
    send_fields(spm_pkg::ACT_STAY, 0, 1'b0);
    send_fields(spm_pkg::ACT_FORWARD, 0, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, 4096, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, -32768, 1'b0);
    drain();

    // full gains: integral climbs close to its limit, steering clips
    program_regs(16'(spm_pkg::MODE_PID), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                 16'd1500, 16'd2000, 16'd1000, 16'd2000);
    send_fields(spm_pkg::ACT_RIGHT, 32767, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, -32768, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, 1, 1'b1);
    send_fields(spm_pkg::ACT_LEFT, -1, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, 0, 1'b0);
    send_fields(spm_pkg::ACT_FORWARD, -32768, 1'b1);
    drain();

    // derivative only: falling error drives u below zero
    program_regs(16'(spm_pkg::MODE_PD), 16'd0, 16'hFFFF, 16'd0,
                 16'd1500, 16'd1600, 16'd1400, 16'd1600);
    send_fields(spm_pkg::ACT_RIGHT, 32767, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, 0, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, 32767, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, 0, 1'b0);
    drain();

    // relay with width registers outside the legal pulse range
    program_regs(16'(spm_pkg::MODE_RELAY), 16'd256, 16'd0, 16'd0,
                 16'hFFFF, 16'd2000, 16'd0, 16'd2047);
    send_fields(spm_pkg::ACT_LEFT, 5, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, 5, 1'b0);
    send_fields(spm_pkg::ACT_STAY, 0, 1'b0);
    send_fields(spm_pkg::ACT_FORWARD, 0, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, 5, 1'b1);
    drain();

    program_regs(16'(spm_pkg::MODE_P), 16'h0100, 16'd0, 16'd0,
                 16'd1000, 16'd1600, 16'd1400, 16'd1600);
    send_fields(spm_pkg::ACT_LEFT, 32767, 1'b0);
    send_fields(spm_pkg::ACT_RIGHT, 12345, 1'b0);
    send_fields(spm_pkg::ACT_LEFT, -32768, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 55;
      end else if (ph < 7) begin
        send_idle_pct = 55;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      program_regs({14'($urandom), 2'(ph % 4)}, rand_gain(), rand_gain(), rand_gain(),
                   rand_width(), rand_width(), rand_width(), rand_width());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 40 && (ph == 5 || ph == 8)) hold_requests++;
        send_cmd(rand_cmd());
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_pulses.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
